@@ design/pcf_pkg.sv @@
// shared types and constants for the pair contact force block
`default_nettype none
package pcf_pkg;
  localparam int FRAC_BITS = 16;

  localparam logic REG_SPRING  = 1'b0;
  localparam logic REG_DAMPING = 1'b1;

  localparam logic [30:0] SPRING_RST  = 31'd65536;
  localparam logic [30:0] DAMPING_RST = 31'd0;

  // pair data that travels alongside the arithmetic
  typedef struct packed {
    logic               hit;
    logic               dx_neg;
    logic               dy_neg;
    logic [31:0]        adx;
    logic [31:0]        ady;
    logic [31:0]        s;
    logic signed [32:0] dvx;
    logic signed [32:0] dvy;
  } pass_t;

  // square root working state
  typedef struct packed {
    logic [34:0] rem;
    logic [31:0] root;
    logic [63:0] v;
  } sq_t;
endpackage
`default_nettype wire

@@ design/pcf_in_if.sv @@
// input, result and configuration channel interfaces
`default_nettype none
interface pcf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] first_pos_x;
  logic signed [31:0] first_pos_y;
  logic signed [31:0] second_pos_x;
  logic signed [31:0] second_pos_y;
  logic signed [31:0] first_vel_x;
  logic signed [31:0] first_vel_y;
  logic signed [31:0] second_vel_x;
  logic signed [31:0] second_vel_y;
  logic [30:0]        first_radius;
  logic [30:0]        second_radius;
  logic               pair_active;
  modport source (output valid, first_pos_x, first_pos_y, second_pos_x, second_pos_y,
                  first_vel_x, first_vel_y, second_vel_x, second_vel_y,
                  first_radius, second_radius, pair_active, input ready);
  modport sink (input valid, first_pos_x, first_pos_y, second_pos_x, second_pos_y,
                first_vel_x, first_vel_y, second_vel_x, second_vel_y,
                first_radius, second_radius, pair_active, output ready);
endinterface

interface pcf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] force_x;
  logic signed [31:0] force_y;
  logic               in_contact;
  modport source (output valid, force_x, force_y, in_contact, input ready);
  modport sink (input valid, force_x, force_y, in_contact, output ready);
endinterface

interface pcf_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ design/pair_contact_force_2d.sv @@
// linear spring-dashpot contact force for one particle pair per cycle
// throughput: one pair per cycle; 32 square-root cells and FRAC_BITS+1 divider cells
// each hold one pair, the whole pipeline holds only while a result waits unread
// reset: synchronous active-low rst_n clears all valid bits and loads the
// spring constant with 1.0 and the damping constant with 0
`default_nettype none
module pair_contact_force_2d #(
  parameter int FRAC_BITS = pcf_pkg::FRAC_BITS
) (
  input wire logic  clk,
  input wire logic  rst_n,
  pcf_in_if.sink    in_if,
  pcf_out_if.source out_if,
  pcf_cfg_if.sink   cfg_if
);
  localparam int QW  = FRAC_BITS + 1;
  localparam int NW  = FRAC_BITS + 2;
  localparam int VPW = 33 + NW;
  localparam int VDW = VPW + 1;
  localparam int VNW = VDW - 1 - FRAC_BITS;
  localparam int DPW = 31 + VNW;
  localparam int FNW = 67 - FRAC_BITS;
  localparam int FPW = FNW + QW;

  logic [30:0] spring_r, damping_r;
  logic        en;

  // configuration registers
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spring_r  <= pcf_pkg::SPRING_RST;
      damping_r <= pcf_pkg::DAMPING_RST;
    end else if (cfg_if.valid) begin
      if (cfg_if.index == pcf_pkg::REG_SPRING) spring_r <= cfg_if.data[30:0];
      else damping_r <= cfg_if.data[30:0];
    end
  end

  logic out_vld_r;
  assign en          = !out_vld_r || out_if.ready;
  assign in_if.ready = en;

  // stage 1: differences and radius sum
  logic               s1_vld_r, s1_act_r;
  logic signed [32:0] s1_dx_r, s1_dy_r, s1_dvx_r, s1_dvy_r;
  logic [31:0]        s1_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else if (en) s1_vld_r <= in_if.valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_act_r <= in_if.pair_active;
      s1_dx_r  <= {in_if.first_pos_x[31], in_if.first_pos_x}
                - {in_if.second_pos_x[31], in_if.second_pos_x};
      s1_dy_r  <= {in_if.first_pos_y[31], in_if.first_pos_y}
                - {in_if.second_pos_y[31], in_if.second_pos_y};
      s1_dvx_r <= {in_if.second_vel_x[31], in_if.second_vel_x}
                - {in_if.first_vel_x[31], in_if.first_vel_x};
      s1_dvy_r <= {in_if.second_vel_y[31], in_if.second_vel_y}
                - {in_if.first_vel_y[31], in_if.first_vel_y};
      s1_s_r   <= {1'b0, in_if.first_radius} + {1'b0, in_if.second_radius};
    end
  end

  // stage 2: magnitudes, box test and squares
  logic [32:0]    adx33, ady33;
  pcf_pkg::pass_t s2_pass_nxt, s2_pass_r;
  logic           s2_vld_r;
  logic [63:0]    s2_dx2_r, s2_dy2_r, s2_s2_r;

  always_comb begin
    adx33 = s1_dx_r[32] ? 33'(-s1_dx_r) : 33'(s1_dx_r);
    ady33 = s1_dy_r[32] ? 33'(-s1_dy_r) : 33'(s1_dy_r);
    s2_pass_nxt.hit    = s1_act_r && (adx33 < {1'b0, s1_s_r}) && (ady33 < {1'b0, s1_s_r});
    s2_pass_nxt.dx_neg = s1_dx_r[32];
    s2_pass_nxt.dy_neg = s1_dy_r[32];
    s2_pass_nxt.adx    = adx33[31:0];
    s2_pass_nxt.ady    = ady33[31:0];
    s2_pass_nxt.s      = s1_s_r;
    s2_pass_nxt.dvx    = s1_dvx_r;
    s2_pass_nxt.dvy    = s1_dvy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else if (en) s2_vld_r <= s1_vld_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s2_pass_r <= s2_pass_nxt;
      s2_dx2_r  <= adx33[31:0] * adx33[31:0];
      s2_dy2_r  <= ady33[31:0] * ady33[31:0];
      s2_s2_r   <= s1_s_r * s1_s_r;
    end
  end

  // stage 3: squared distance against squared radius sum
  logic [64:0]    rsq65;
  pcf_pkg::pass_t s3_pass_nxt;
  pcf_pkg::sq_t   s3_sq_nxt;

  always_comb begin
    rsq65           = {1'b0, s2_dx2_r} + {1'b0, s2_dy2_r};
    s3_pass_nxt     = s2_pass_r;
    s3_pass_nxt.hit = s2_pass_r.hit && (rsq65 < {1'b0, s2_s2_r});
    s3_sq_nxt.rem   = '0;
    s3_sq_nxt.root  = '0;
    s3_sq_nxt.v     = rsq65[63:0];
  end

  logic           sq_vld  [0:32];
  pcf_pkg::pass_t sq_pass [0:32];
  pcf_pkg::sq_t   sq_st   [0:32];

  always_ff @(posedge clk) begin
    if (!rst_n) sq_vld[0] <= 1'b0;
    else if (en) sq_vld[0] <= s2_vld_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sq_pass[0] <= s3_pass_nxt;
      sq_st[0]   <= s3_sq_nxt;
    end
  end

  // square root chain, one result bit per cell
  for (genvar i = 0; i < 32; i++) begin : g_sqrt
    pcf_sqrt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (sq_vld[i]),
      .pass_i (sq_pass[i]),
      .sq_i   (sq_st[i]),
      .vld_o  (sq_vld[i+1]),
      .pass_o (sq_pass[i+1]),
      .sq_o   (sq_st[i+1])
    );
  end

  // divider chain for the unit normal
  logic           dv_vld  [0:QW];
  pcf_pkg::pass_t dv_pass [0:QW];
  logic [31:0]    dv_r    [0:QW];
  logic [32:0]    dv_rx   [0:QW];
  logic [32:0]    dv_ry   [0:QW];
  logic [QW-1:0]  dv_qx   [0:QW];
  logic [QW-1:0]  dv_qy   [0:QW];

  always_comb begin
    dv_vld[0]      = sq_vld[32];
    dv_pass[0]     = sq_pass[32];
    dv_pass[0].hit = sq_pass[32].hit && (sq_st[32].root != 32'd0);
    dv_r[0]        = sq_st[32].root;
    dv_rx[0]       = {1'b0, sq_pass[32].adx};
    dv_ry[0]       = {1'b0, sq_pass[32].ady};
    dv_qx[0]       = '0;
    dv_qy[0]       = '0;
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    pcf_div_cell #(.QW(QW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (dv_vld[j]),
      .pass_i (dv_pass[j]),
      .r_i    (dv_r[j]),
      .rx_i   (dv_rx[j]),
      .ry_i   (dv_ry[j]),
      .qx_i   (dv_qx[j]),
      .qy_i   (dv_qy[j]),
      .vld_o  (dv_vld[j+1]),
      .pass_o (dv_pass[j+1]),
      .r_o    (dv_r[j+1]),
      .rx_o   (dv_rx[j+1]),
      .ry_o   (dv_ry[j+1]),
      .qx_o   (dv_qx[j+1]),
      .qy_o   (dv_qy[j+1])
    );
  end

  // stage 5: velocity projections and spring product
  logic signed [NW-1:0]  nx, ny;
  logic [31:0]           pen;
  logic                  s5_vld_r;
  pcf_pkg::pass_t        s5_pass_r;
  logic [QW-1:0]         s5_qx_r, s5_qy_r;
  logic signed [VPW-1:0] s5_vpx_r, s5_vpy_r;
  logic [62:0]           s5_sp_r;

  always_comb begin
    nx  = dv_pass[QW].dx_neg ? -$signed({1'b0, dv_qx[QW]}) : $signed({1'b0, dv_qx[QW]});
    ny  = dv_pass[QW].dy_neg ? -$signed({1'b0, dv_qy[QW]}) : $signed({1'b0, dv_qy[QW]});
    pen = dv_pass[QW].s - dv_r[QW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s5_vld_r <= 1'b0;
    else if (en) s5_vld_r <= dv_vld[QW];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s5_pass_r <= dv_pass[QW];
      s5_qx_r   <= dv_qx[QW];
      s5_qy_r   <= dv_qy[QW];
      s5_vpx_r  <= VPW'(dv_pass[QW].dvx * nx);
      s5_vpy_r  <= VPW'(dv_pass[QW].dvy * ny);
      s5_sp_r   <= spring_r * pen;
    end
  end

  // stage 6: normal approach speed
  logic                  s6_vld_r;
  pcf_pkg::pass_t        s6_pass_r;
  logic [QW-1:0]         s6_qx_r, s6_qy_r;
  logic signed [VDW-1:0] s6_vdot_r;
  logic [62:0]           s6_sp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s6_vld_r <= 1'b0;
    else if (en) s6_vld_r <= s5_vld_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s6_pass_r <= s5_pass_r;
      s6_qx_r   <= s5_qx_r;
      s6_qy_r   <= s5_qy_r;
      s6_vdot_r <= VDW'(s5_vpx_r) + VDW'(s5_vpy_r);
      s6_sp_r   <= s5_sp_r >> FRAC_BITS;
    end
  end

  // stage 7: damping product, receding pairs clamp to zero
  logic [VNW-1:0] vn;
  logic           s7_vld_r;
  pcf_pkg::pass_t s7_pass_r;
  logic [QW-1:0]  s7_qx_r, s7_qy_r;
  logic [DPW-1:0] s7_dp_r;
  logic [62:0]    s7_sp_r;

  assign vn = (!s6_vdot_r[VDW-1] && (s6_vdot_r != '0)) ? s6_vdot_r[VDW-2:FRAC_BITS] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) s7_vld_r <= 1'b0;
    else if (en) s7_vld_r <= s6_vld_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s7_pass_r <= s6_pass_r;
      s7_qx_r   <= s6_qx_r;
      s7_qy_r   <= s6_qy_r;
      s7_dp_r   <= DPW'(damping_r * vn);
      s7_sp_r   <= s6_sp_r;
    end
  end

  // stage 8: normal force magnitude
  logic [DPW-1:0] dp_sh;
  logic           s8_vld_r;
  pcf_pkg::pass_t s8_pass_r;
  logic [QW-1:0]  s8_qx_r, s8_qy_r;
  logic [FNW-1:0] s8_fn_r;

  assign dp_sh = s7_dp_r >> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) s8_vld_r <= 1'b0;
    else if (en) s8_vld_r <= s7_vld_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s8_pass_r <= s7_pass_r;
      s8_qx_r   <= s7_qx_r;
      s8_qy_r   <= s7_qy_r;
      s8_fn_r   <= FNW'(s7_sp_r) + FNW'(dp_sh);
    end
  end

  // stage 9: force components
  logic           s9_vld_r;
  pcf_pkg::pass_t s9_pass_r;
  logic [FPW-1:0] s9_fx_r, s9_fy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s9_vld_r <= 1'b0;
    else if (en) s9_vld_r <= s8_vld_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s9_pass_r <= s8_pass_r;
      s9_fx_r   <= s8_fn_r * s8_qx_r;
      s9_fy_r   <= s8_fn_r * s8_qy_r;
    end
  end

  // stage 10: saturation into the output register
  logic [FPW-1:0] mx, my;
  logic [31:0]    fx_nxt, fy_nxt;

  always_comb begin
    mx = s9_fx_r >> FRAC_BITS;
    my = s9_fy_r >> FRAC_BITS;
    if (!s9_pass_r.hit) fx_nxt = '0;
    else if (s9_pass_r.dx_neg) fx_nxt = (mx > FPW'(33'h080000000)) ? 32'h80000000 : -mx[31:0];
    else fx_nxt = (mx > FPW'(32'h7fffffff)) ? 32'h7fffffff : mx[31:0];
    if (!s9_pass_r.hit) fy_nxt = '0;
    else if (s9_pass_r.dy_neg) fy_nxt = (my > FPW'(33'h080000000)) ? 32'h80000000 : -my[31:0];
    else fy_nxt = (my > FPW'(32'h7fffffff)) ? 32'h7fffffff : my[31:0];
  end

  logic [31:0] fx_r, fy_r;
  logic        contact_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= s9_vld_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      fx_r      <= fx_nxt;
      fy_r      <= fy_nxt;
      contact_r <= s9_pass_r.hit;
    end
  end

  assign out_if.valid      = out_vld_r;
  assign out_if.force_x    = fx_r;
  assign out_if.force_y    = fy_r;
  assign out_if.in_contact = contact_r;
endmodule
`default_nettype wire

@@ design/pcf_sqrt_cell.sv @@
// one bit of the integer square root, registered
`default_nettype none
module pcf_sqrt_cell (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           vld_i,
  input  wire pcf_pkg::pass_t pass_i,
  input  wire pcf_pkg::sq_t   sq_i,
  output logic                vld_o,
  output pcf_pkg::pass_t      pass_o,
  output pcf_pkg::sq_t        sq_o
);
  logic [34:0]  rem_sh;
  logic [34:0]  trial;
  logic         ge;
  pcf_pkg::sq_t sq_nxt;
  logic         vld_r;
  pcf_pkg::pass_t pass_r;
  pcf_pkg::sq_t sq_r;

  always_comb begin
    rem_sh      = {sq_i.rem[32:0], sq_i.v[63:62]};
    trial       = {1'b0, sq_i.root, 2'b01};
    ge          = (rem_sh >= trial);
    sq_nxt.rem  = ge ? (rem_sh - trial) : rem_sh;
    sq_nxt.root = {sq_i.root[30:0], ge};
    sq_nxt.v    = {sq_i.v[61:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (en) vld_r <= vld_i;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pass_r <= pass_i;
      sq_r   <= sq_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign pass_o = pass_r;
  assign sq_o   = sq_r;
endmodule
`default_nettype wire

@@ design/pcf_div_cell.sv @@
// one quotient bit of both normal components, registered
`default_nettype none
module pcf_div_cell #(
  parameter int QW = pcf_pkg::FRAC_BITS + 1
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           vld_i,
  input  wire pcf_pkg::pass_t pass_i,
  input  wire logic [31:0]    r_i,
  input  wire logic [32:0]    rx_i,
  input  wire logic [32:0]    ry_i,
  input  wire logic [QW-1:0]  qx_i,
  input  wire logic [QW-1:0]  qy_i,
  output logic                vld_o,
  output pcf_pkg::pass_t      pass_o,
  output logic [31:0]         r_o,
  output logic [32:0]         rx_o,
  output logic [32:0]         ry_o,
  output logic [QW-1:0]       qx_o,
  output logic [QW-1:0]       qy_o
);
  logic        gx, gy;
  logic [32:0] dx, dy;
  logic        vld_r;
  pcf_pkg::pass_t pass_r;
  logic [31:0] r_r;
  logic [32:0] rx_r, ry_r;
  logic [QW-1:0] qx_r, qy_r;

  always_comb begin
    gx = (rx_i >= {1'b0, r_i});
    gy = (ry_i >= {1'b0, r_i});
    dx = gx ? (rx_i - {1'b0, r_i}) : rx_i;
    dy = gy ? (ry_i - {1'b0, r_i}) : ry_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (en) vld_r <= vld_i;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pass_r <= pass_i;
      r_r    <= r_i;
      rx_r   <= {dx[31:0], 1'b0};
      ry_r   <= {dy[31:0], 1'b0};
      qx_r   <= {qx_i[QW-2:0], gx};
      qy_r   <= {qy_i[QW-2:0], gy};
    end
  end

  assign vld_o  = vld_r;
  assign pass_o = pass_r;
  assign r_o    = r_r;
  assign rx_o   = rx_r;
  assign ry_o   = ry_r;
  assign qx_o   = qx_r;
  assign qy_o   = qy_r;
endmodule
`default_nettype wire

@@ design/pcf_checker.sv @@
// port-level checks for the pair contact force block, bound to the top level
`default_nettype none
module pcf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] force_x,
  input wire logic [31:0] force_y,
  input wire logic        in_contact
);
  // a waiting result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(force_x) && $stable(force_y))
    else $error("result beat changed while stalled");

  // no contact means no force
  a_zero_force: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !in_contact |-> force_x == 32'd0 && force_y == 32'd0)
    else $error("force without contact");

  // a stalled result holds the whole pipeline
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline stalled");

  // reset empties the output register
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  // an empty output register never refuses an input beat
  a_ready_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !out_valid |-> in_ready)
    else $error("input refused with empty output register");
endmodule

bind pair_contact_force_2d pcf_checker u_pcf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .force_x    (out_if.force_x),
  .force_y    (out_if.force_y),
  .in_contact (out_if.in_contact)
);
`default_nettype wire
